// File: rtl/sfc_pkg.sv
// ----------------------------------------------------------------------------
// sfc_pkg
// Shared types and constants of the segmented FIFO cache policy block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfc_pkg;

    localparam int CAPACITY_DEF  = 64;
    localparam int ADDR_BITS_DEF = 31;
    localparam int MAX_LISTS     = 4;
    localparam int SIZE_REGS     = 4;
    localparam int SIZE_W        = 7;
    localparam int LAYOUT_W      = 9;
    localparam int CNT_W         = 32;
    localparam int CFG_W         = 7;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        CFG_NUM_LISTS,
        CFG_LIST0_SIZE,
        CFG_LIST1_SIZE,
        CFG_LIST2_SIZE,
        CFG_LIST3_SIZE,
        CFG_STRICT_PROMOTE,
        CFG_LRU_LAST
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_LOCATE,
        ST_PLAN,
        ST_APPLY
    } state_t;

    typedef struct packed {
        logic                                ok;
        logic [2:0]                          num;
        logic [SIZE_REGS-1:0][LAYOUT_W-1:0]  base;
        logic [SIZE_REGS-1:0][SIZE_W-1:0]    size;
        logic [LAYOUT_W-1:0]                 total;
    } layout_t;

    typedef struct packed {
        logic              apply;
        logic              do_push;
        logic              do_fill;
        logic              do_shift;
        logic [1:0]        list;
        logic [SIZE_W-1:0] pos;
        logic [SIZE_W-1:0] head;
    } cell_ctl_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// File: rtl/sfc_layout.sv
// ----------------------------------------------------------------------------
// sfc_layout
// Decodes list sizes into slot bases and checks the configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_layout #(
    parameter int CAPACITY = sfc_pkg::CAPACITY_DEF
) (
    input  wire logic [2:0]                                          num_lists,
    input  wire logic [sfc_pkg::SIZE_REGS-1:0][sfc_pkg::SIZE_W-1:0]  list_size,
    output sfc_pkg::layout_t                                         layout
);

    always_comb begin
        logic [sfc_pkg::LAYOUT_W-1:0] sum;
        logic                         ok;
        sum = '0;
        ok  = (num_lists != 3'd0) && (int'(num_lists) <= sfc_pkg::MAX_LISTS)
              && (int'(num_lists) <= sfc_pkg::SIZE_REGS);
        layout = '0;
        for (int l = 0; l < sfc_pkg::SIZE_REGS; l++) begin
            layout.base[l] = sum;
            layout.size[l] = list_size[l];
            if (l < int'(num_lists)) begin
                if (list_size[l] == '0) begin
                    ok = 1'b0;
                end
                sum = sum + sfc_pkg::LAYOUT_W'(list_size[l]);
            end
        end
        layout.total = sum;
        layout.num   = num_lists;
        layout.ok    = ok && (int'(sum) <= CAPACITY);
    end

endmodule

`default_nettype wire

// File: rtl/sfc_cell.sv
// ----------------------------------------------------------------------------
// sfc_cell
// One cache slot: holds valid bit and address, compares against the key and
// takes its neighbor's entry when its list shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module sfc_cell #(
    parameter int IDX = 0,
    parameter int LW  = 10,
    parameter int EW  = 32
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              clear,
    input  wire sfc_pkg::cell_ctl_t ctl,
    input  wire sfc_pkg::layout_t  layout,
    input  wire logic [EW-1:0]     key,
    input  wire logic [LW-1:0]     push_idx,
    input  wire logic [LW-1:0]     found_idx,
    input  wire logic [EW-1:0]     front_val,
    input  wire logic [EW-1:0]     wrap_val,
    input  wire logic [EW-1:0]     left_val,
    output logic      [EW-1:0]     value,
    output logic                   match
);

    localparam logic [LW-1:0] SELF = LW'(IDX);

    logic [EW-1:0]             value_reg;
    logic [EW-1:0]             value_next;
    logic [LW-1:0]             base_l;
    logic [LW-1:0]             end_l;
    logic                      in_list;
    logic [sfc_pkg::SIZE_W-1:0] rel_idx;
    logic [sfc_pkg::SIZE_W-1:0] lpos;

    assign base_l  = LW'(layout.base[ctl.list]);
    assign end_l   = base_l + LW'(layout.size[ctl.list]);
    assign in_list = (SELF >= base_l) && (SELF < end_l);
    assign rel_idx = sfc_pkg::SIZE_W'(SELF - base_l);
    assign lpos    = (rel_idx >= ctl.head) ? rel_idx - ctl.head
                                           : rel_idx - ctl.head + layout.size[ctl.list];

    assign value = value_reg;
    assign match = (value_reg == key) && (SELF < LW'(layout.total));

    always_comb begin
        value_next = value_reg;
        if (clear) begin
            value_next = '0;
        end else if (ctl.apply) begin
            if (ctl.do_shift && in_list) begin
                if (lpos == '0) begin
                    value_next = front_val;
                end else if (lpos <= ctl.pos) begin
                    // the list's first slot takes the entry from its last slot
                    value_next = (SELF == base_l) ? wrap_val : left_val;
                end
            end
            if (ctl.do_fill && (SELF == found_idx)) begin
                value_next = front_val;
            end
            if (ctl.do_push && (SELF == push_idx)) begin
                value_next = key;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg <= '0;
        end else begin
            value_reg <= value_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/segmented_fifo_cache_policy.sv
// ----------------------------------------------------------------------------
// segmented_fifo_cache_policy
// Fully associative cache of chained circular FIFO lists held in a row of
// slot cells; searches by content, inserts misses and promotes hits.
// ----------------------------------------------------------------------------
//  channel  | ports                               | role
//  ---------+-------------------------------------+-----------------------------
//  s_       | s_valid s_ready s_addr              | access address in
//  m_       | m_valid m_ready m_hit ... m_config_ | one result per access
//  cfg_     | cfg_we cfg_index cfg_data           | register write, clears state
//
//  An access runs through the steps accept, search across all slot cells, locate
//  the hit, plan the push slot and apply the update to the cell row.
//  The apply step waits while the output register holds an untaken result.
//  After reset or any write to a defined register index every slot is empty and counters are zero.
// ----------------------------------------------------------------------------
`default_nettype none

module segmented_fifo_cache_policy #(
    parameter int CAPACITY  = sfc_pkg::CAPACITY_DEF,
    parameter int ADDR_BITS = sfc_pkg::ADDR_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic [ADDR_BITS-1:0]      s_addr,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic                           m_hit,
    output logic [1:0]                     m_hit_list,
    output logic [5:0]                     m_hit_position,
    output logic                           m_evicted_valid,
    output logic [ADDR_BITS-1:0]           m_evicted_addr,
    output logic [sfc_pkg::CNT_W-1:0]      m_access_count,
    output logic [sfc_pkg::CNT_W-1:0]      m_miss_count,
    output logic [sfc_pkg::CNT_W-1:0]      m_fill_access_count,
    output logic [sfc_pkg::CNT_W-1:0]      m_fill_miss_count,
    output logic                           m_config_error,
    input  wire logic                      cfg_we,
    input  wire logic [2:0]                cfg_index,
    input  wire logic [sfc_pkg::CFG_W-1:0] cfg_data
);

    localparam int EW     = ADDR_BITS + 1;
    localparam int LW     = $clog2(CAPACITY + 512);
    localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SW     = sfc_pkg::SIZE_W;
    localparam int CW     = sfc_pkg::CNT_W;
    localparam int NL     = sfc_pkg::SIZE_REGS;

    // configuration
    logic [2:0]             num_lists_reg;
    logic [NL-1:0][SW-1:0]  size_reg;
    logic                   strict_reg;
    logic                   lru_reg;
    logic                   clear;

    // state
    sfc_pkg::state_t        state_reg, state_next;
    logic [SW-1:0]          head_reg [NL];
    logic [LW-1:0]          occ_reg;
    logic [CW-1:0]          acc_reg, miss_reg, fill_acc_reg, fill_miss_reg;

    // per-access work registers
    logic [EW-1:0]          key_reg;
    logic [CAPACITY-1:0]    match_reg;
    logic                   hit_reg;
    logic [LW-1:0]          found_reg;
    logic [1:0]             list_reg;
    logic [SW-1:0]          pos_reg;
    logic                   last_reg;
    logic                   push_reg;
    logic [1:0]             push_list_reg;
    logic [SW-1:0]          push_head_reg;
    logic [LW-1:0]          push_idx_reg;
    logic [EW-1:0]          push_old_reg;
    logic [EW-1:0]          wrap_reg;

    // output register
    logic                   m_valid_reg;
    logic                   o_hit_reg, o_ev_valid_reg, o_err_reg;
    logic [1:0]             o_list_reg;
    logic [5:0]             o_pos_reg;
    logic [ADDR_BITS-1:0]   o_ev_addr_reg;
    logic [CW-1:0]          o_acc_reg, o_miss_reg, o_fill_acc_reg, o_fill_miss_reg;

    sfc_pkg::layout_t       layout;
    sfc_pkg::cell_ctl_t     ctl;
    logic [EW-1:0]          cell_val   [CAPACITY];
    logic [CAPACITY-1:0]    cell_match;
    logic [EW-1:0]          front_val;

    logic                   out_free;
    logic                   apply_go;
    logic                   miss;
    logic                   not_full;

    // locate results
    logic [LW-1:0]          found_c;
    logic [1:0]             list_c;
    logic [SW-1:0]          dist_c;
    logic [SW-1:0]          pos_c;

    // plan results
    logic                   last_c;
    logic [1:0]             push_list_c;
    logic [SW-1:0]          push_head_c;
    logic [LW-1:0]          push_idx_c;
    logic [LW-1:0]          wrap_idx_c;

    // apply results
    logic [CW-1:0]          acc_next, miss_next, fill_acc_next, fill_miss_next;

    sfc_layout #(
        .CAPACITY (CAPACITY)
    ) u_layout (
        .num_lists (num_lists_reg),
        .list_size (size_reg),
        .layout    (layout)
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        sfc_cell #(
            .IDX (i),
            .LW  (LW),
            .EW  (EW)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .clear     (clear),
            .ctl       (ctl),
            .layout    (layout),
            .key       (key_reg),
            .push_idx  (push_idx_reg),
            .found_idx (found_reg),
            .front_val (front_val),
            .wrap_val  (wrap_reg),
            .left_val  (cell_val[(i + CAPACITY - 1) % CAPACITY]),
            .value     (cell_val[i]),
            .match     (cell_match[i])
        );
    end

    assign clear    = cfg_we && (cfg_index <= sfc_pkg::CFG_LRU_LAST);
    assign out_free = !m_valid_reg || m_ready;
    assign miss     = !hit_reg;
    assign not_full = occ_reg < LW'(layout.total);

    // locate: slot entries are unique, so at most one match bit is set
    always_comb begin
        found_c = '0;
        for (int s = 0; s < CAPACITY; s++) begin
            if (match_reg[s]) begin
                found_c = found_c | LW'(s);
            end
        end
        list_c = '0;
        for (int l = 1; l < NL; l++) begin
            if ((l < int'(num_lists_reg)) && (found_c >= LW'(layout.base[l]))) begin
                list_c = 2'(l);
            end
        end
        dist_c = SW'(found_c - LW'(layout.base[list_c]));
        pos_c  = (dist_c >= head_reg[list_c]) ? dist_c - head_reg[list_c]
                 : dist_c - head_reg[list_c] + layout.size[list_c];
    end

    // plan: slot that the push lands in, and the wrap source of the hit list
    always_comb begin
        last_c      = ({1'b0, list_reg} == (num_lists_reg - 3'd1));
        push_list_c = hit_reg ? list_reg + 2'd1 : 2'd0;
        push_head_c = (head_reg[push_list_c] == '0) ? layout.size[push_list_c] - 1'b1
                                                    : head_reg[push_list_c] - 1'b1;
        push_idx_c  = LW'(layout.base[push_list_c]) + LW'(push_head_c);
        wrap_idx_c  = LW'(layout.base[list_reg]) + LW'(layout.size[list_reg]) - 1'b1;
    end

    // apply
    always_comb begin
        acc_next       = sfc_pkg::sat_inc(acc_reg);
        miss_next      = miss ? sfc_pkg::sat_inc(miss_reg) : miss_reg;
        fill_acc_next  = not_full ? acc_next : fill_acc_reg;
        fill_miss_next = (miss && not_full) ? miss_next : fill_miss_reg;

        apply_go     = (state_reg == sfc_pkg::ST_APPLY) && out_free;
        ctl.apply    = apply_go && layout.ok;
        ctl.do_push  = push_reg;
        ctl.do_fill  = hit_reg && !last_reg && !strict_reg && !lru_reg;
        ctl.do_shift = hit_reg && ((!last_reg && (strict_reg || lru_reg))
                                   || (last_reg && lru_reg));
        ctl.list     = list_reg;
        ctl.pos      = pos_reg;
        ctl.head     = head_reg[list_reg];
        front_val    = (hit_reg && last_reg) ? key_reg : push_old_reg;
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        case (state_reg)
            sfc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = sfc_pkg::ST_SEARCH;
                end
            end
            sfc_pkg::ST_SEARCH: state_next = sfc_pkg::ST_LOCATE;
            sfc_pkg::ST_LOCATE: state_next = sfc_pkg::ST_PLAN;
            sfc_pkg::ST_PLAN:   state_next = sfc_pkg::ST_APPLY;
            sfc_pkg::ST_APPLY: begin
                if (out_free) begin
                    state_next = sfc_pkg::ST_IDLE;
                end
            end
            default: state_next = sfc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sfc_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration and cache control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_lists_reg <= 3'd1;
            for (int l = 0; l < NL; l++) begin
                size_reg[l] <= SW'(16);
                head_reg[l] <= '0;
            end
            strict_reg    <= 1'b0;
            lru_reg       <= 1'b0;
            occ_reg       <= '0;
            acc_reg       <= '0;
            miss_reg      <= '0;
            fill_acc_reg  <= '0;
            fill_miss_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                sfc_pkg::CFG_NUM_LISTS:      num_lists_reg <= cfg_data[2:0];
                sfc_pkg::CFG_LIST0_SIZE:     size_reg[0]   <= cfg_data[SW-1:0];
                sfc_pkg::CFG_LIST1_SIZE:     size_reg[1]   <= cfg_data[SW-1:0];
                sfc_pkg::CFG_LIST2_SIZE:     size_reg[2]   <= cfg_data[SW-1:0];
                sfc_pkg::CFG_LIST3_SIZE:     size_reg[3]   <= cfg_data[SW-1:0];
                sfc_pkg::CFG_STRICT_PROMOTE: strict_reg    <= cfg_data[0];
                sfc_pkg::CFG_LRU_LAST:       lru_reg       <= cfg_data[0];
                default: ;
            endcase
            if (clear) begin
                for (int l = 0; l < NL; l++) begin
                    head_reg[l] <= '0;
                end
                occ_reg       <= '0;
                acc_reg       <= '0;
                miss_reg      <= '0;
                fill_acc_reg  <= '0;
                fill_miss_reg <= '0;
            end
        end else if (ctl.apply) begin
            acc_reg       <= acc_next;
            miss_reg      <= miss_next;
            fill_acc_reg  <= fill_acc_next;
            fill_miss_reg <= fill_miss_next;
            if (push_reg) begin
                head_reg[push_list_reg] <= push_head_reg;
            end
            if (miss && !push_old_reg[EW-1]) begin
                occ_reg <= occ_reg + 1'b1;
            end
        end
    end

    // per-access datapath
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            key_reg <= {1'b1, s_addr};
        end
        if (state_reg == sfc_pkg::ST_SEARCH) begin
            match_reg <= cell_match;
        end
        if (state_reg == sfc_pkg::ST_LOCATE) begin
            hit_reg   <= |match_reg;
            found_reg <= found_c;
            list_reg  <= (|match_reg) ? list_c : 2'd0;
            pos_reg   <= (|match_reg) ? pos_c : '0;
        end
        if (state_reg == sfc_pkg::ST_PLAN) begin
            last_reg      <= last_c;
            push_reg      <= !hit_reg || !last_c;
            push_list_reg <= push_list_c;
            push_head_reg <= push_head_c;
            push_idx_reg  <= push_idx_c;
            push_old_reg  <= cell_val[push_idx_c[SLOT_W-1:0]];
            wrap_reg      <= cell_val[wrap_idx_c[SLOT_W-1:0]];
        end
    end

    // output register: hold until transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (apply_go) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (apply_go) begin
            o_err_reg <= !layout.ok;
            if (layout.ok) begin
                o_hit_reg       <= hit_reg;
                o_list_reg      <= list_reg;
                o_pos_reg       <= pos_reg[5:0];
                o_ev_valid_reg  <= miss && push_old_reg[EW-1];
                o_ev_addr_reg   <= (miss && push_old_reg[EW-1]) ?
                                   push_old_reg[ADDR_BITS-1:0] : '0;
                o_acc_reg       <= acc_next;
                o_miss_reg      <= miss_next;
                o_fill_acc_reg  <= fill_acc_next;
                o_fill_miss_reg <= fill_miss_next;
            end else begin
                o_hit_reg       <= 1'b0;
                o_list_reg      <= '0;
                o_pos_reg       <= '0;
                o_ev_valid_reg  <= 1'b0;
                o_ev_addr_reg   <= '0;
                o_acc_reg       <= acc_reg;
                o_miss_reg      <= miss_reg;
                o_fill_acc_reg  <= fill_acc_reg;
                o_fill_miss_reg <= fill_miss_reg;
            end
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_hit               = o_hit_reg;
    assign m_hit_list          = o_list_reg;
    assign m_hit_position      = o_pos_reg;
    assign m_evicted_valid     = o_ev_valid_reg;
    assign m_evicted_addr      = o_ev_addr_reg;
    assign m_access_count      = o_acc_reg;
    assign m_miss_count        = o_miss_reg;
    assign m_fill_access_count = o_fill_acc_reg;
    assign m_fill_miss_count   = o_fill_miss_reg;
    assign m_config_error      = o_err_reg;

endmodule

`default_nettype wire

// File: tb/tb_segmented_fifo_cache_policy.sv
// ----------------------------------------------------------------------------
// tb_segmented_fifo_cache_policy
// Drives address accesses through the segmented FIFO cache under several list
// layouts and promotion modes, predicts every result in a local cache model
// and compares each result transfer field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segmented_fifo_cache_policy;

    localparam int CAP = 64;
    localparam int AW  = 31;

    typedef struct packed {
        logic          hit;
        logic [1:0]    hit_list;
        logic [5:0]    hit_position;
        logic          evicted_valid;
        logic [AW-1:0] evicted_addr;
        logic [31:0]   access_count;
        logic [31:0]   miss_count;
        logic [31:0]   fill_access_count;
        logic [31:0]   fill_miss_count;
        logic          config_error;
    } access_result_t;

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    logic [AW-1:0] s_addr;
    logic          m_valid;
    logic          m_ready;
    logic          m_hit;
    logic [1:0]    m_hit_list;
    logic [5:0]    m_hit_position;
    logic          m_evicted_valid;
    logic [AW-1:0] m_evicted_addr;
    logic [31:0]   m_access_count;
    logic [31:0]   m_miss_count;
    logic [31:0]   m_fill_access_count;
    logic [31:0]   m_fill_miss_count;
    logic          m_config_error;
    logic          cfg_we;
    logic [2:0]    cfg_index;
    logic [6:0]    cfg_data;

    segmented_fifo_cache_policy u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_addr(s_addr),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_hit(m_hit), .m_hit_list(m_hit_list), .m_hit_position(m_hit_position),
        .m_evicted_valid(m_evicted_valid), .m_evicted_addr(m_evicted_addr),
        .m_access_count(m_access_count), .m_miss_count(m_miss_count),
        .m_fill_access_count(m_fill_access_count),
        .m_fill_miss_count(m_fill_miss_count),
        .m_config_error(m_config_error),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predicted cache state
    logic [2:0]    cur_lists;
    logic [6:0]    cur_size [4];
    logic          cur_strict;
    logic          cur_lru;
    logic [AW:0]   slots [CAP];
    int unsigned   heads [4];
    int unsigned   occupied;
    logic [31:0]   acc_total, n_miss, n_fill_access, n_fill_miss;
    int unsigned   lay_base [5];
    int unsigned   lay_size [4];

    access_result_t expected_results [$];
    int  errors = 0;
    bit  idle_on = 1;
    int  hold_off = 0;
    // recently used addresses, to steer random accesses toward hits
    logic [AW-1:0] recent [$];

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #20000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic [31:0] sat_next(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic void clear_cache();
        for (int i = 0; i < CAP; i++) slots[i] = '0;
        for (int i = 0; i < 4; i++) heads[i] = 0;
        occupied = 0;
        acc_total = 0; n_miss = 0; n_fill_access = 0; n_fill_miss = 0;
    endfunction

    function automatic bit layout_ok();
        int unsigned sum;
        sum = 0;
        if (cur_lists == 0 || cur_lists > 4) return 0;
        for (int l = 0; l < cur_lists; l++) begin
            if (cur_size[l] == 0) return 0;
            lay_size[l] = cur_size[l];
            lay_base[l] = sum;
            sum += cur_size[l];
        end
        lay_base[cur_lists] = sum;
        return sum <= CAP;
    endfunction

    function automatic int unsigned slot_of(int unsigned l, int unsigned p);
        return lay_base[l] + (heads[l] + p) % lay_size[l];
    endfunction

    function automatic logic [AW:0] push_head(int unsigned l, logic [AW:0] e);
        int unsigned nh;
        logic [AW:0] old;
        nh = (heads[l] + lay_size[l] - 1) % lay_size[l];
        old = slots[lay_base[l] + nh];
        slots[lay_base[l] + nh] = e;
        heads[l] = nh;
        return old;
    endfunction

    function automatic void shift_to_head(int unsigned l, int unsigned pos, logic [AW:0] e);
        for (int t = pos; t >= 1; t--) slots[slot_of(l, t)] = slots[slot_of(l, t - 1)];
        slots[slot_of(l, 0)] = e;
    endfunction

    function automatic access_result_t predict_access(logic [AW-1:0] a);
        access_result_t r;
        logic [AW:0] e, old, disp;
        int unsigned total, found, l, pos;
        r = '0;
        e = {1'b1, a};
        if (!layout_ok()) begin
            r.config_error = 1'b1;
        end else begin
            total = lay_base[cur_lists];
            found = CAP;
            acc_total = sat_next(acc_total);
            if (occupied < total) n_fill_access = acc_total;
            for (int s = 0; s < total; s++)
                if (found == CAP && slots[s] == e) found = s;
            if (found == CAP) begin
                n_miss = sat_next(n_miss);
                if (occupied < total) n_fill_miss = n_miss;
                old = push_head(0, e);
                if (old[AW]) begin
                    r.evicted_valid = 1'b1;
                    r.evicted_addr = old[AW-1:0];
                end else begin
                    occupied++;
                end
            end else begin
                l = 0;
                while (l + 1 < cur_lists && found >= lay_base[l + 1]) l++;
                pos = (found - lay_base[l] + lay_size[l] - heads[l]) % lay_size[l];
                r.hit = 1'b1;
                r.hit_list = l[1:0];
                r.hit_position = pos[5:0];
                if (l == cur_lists - 1) begin
                    if (cur_lru && pos > 0) shift_to_head(l, pos, e);
                end else if (!(cur_strict || cur_lru)) begin
                    slots[found] = push_head(l + 1, e);
                end else begin
                    disp = push_head(l + 1, e);
                    shift_to_head(l, pos, disp);
                end
            end
        end
        r.access_count = acc_total;
        r.miss_count = n_miss;
        r.fill_access_count = n_fill_access;
        r.fill_miss_count = n_fill_miss;
        return r;
    endfunction

    task automatic send_access(logic [AW-1:0] a);
        // valid dropped at the previous falling edge; raise it no earlier than the next
        @(negedge aclk);
        while (idle_on && $urandom_range(99) < 12) @(negedge aclk);
        expected_results.push_back(predict_access(a));
        recent.push_back(a);
        if (recent.size() > 96) void'(recent.pop_front());
        s_valid <= 1'b1;
        s_addr <= a;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while (expected_results.size() != 0 && guard < 200000) begin
            @(negedge aclk);
            guard++;
        end
        repeat (12) @(negedge aclk);
    endtask

    task automatic write_reg(sfc_pkg::cfg_reg_t idx, logic [6:0] val);
        drain();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            sfc_pkg::CFG_NUM_LISTS:      cur_lists = val[2:0];
            sfc_pkg::CFG_LIST0_SIZE:     cur_size[0] = val;
            sfc_pkg::CFG_LIST1_SIZE:     cur_size[1] = val;
            sfc_pkg::CFG_LIST2_SIZE:     cur_size[2] = val;
            sfc_pkg::CFG_LIST3_SIZE:     cur_size[3] = val;
            sfc_pkg::CFG_STRICT_PROMOTE: cur_strict = val[0];
            sfc_pkg::CFG_LRU_LAST:       cur_lru = val[0];
            default: ;
        endcase
        clear_cache();
        recent.delete();
    endtask

    task automatic set_layout(int n, int s0, int s1, int s2, int s3, bit st, bit lr);
        write_reg(sfc_pkg::CFG_LIST0_SIZE, s0[6:0]);
        write_reg(sfc_pkg::CFG_LIST1_SIZE, s1[6:0]);
        write_reg(sfc_pkg::CFG_LIST2_SIZE, s2[6:0]);
        write_reg(sfc_pkg::CFG_LIST3_SIZE, s3[6:0]);
        write_reg(sfc_pkg::CFG_STRICT_PROMOTE, {6'd0, st});
        write_reg(sfc_pkg::CFG_LRU_LAST, {6'd0, lr});
        write_reg(sfc_pkg::CFG_NUM_LISTS, n[6:0]);
    endtask

    // mostly reuse a small address pool so hits climb through the lists
    function automatic logic [AW-1:0] pick_addr();
        int k;
        k = $urandom_range(99);
        if (k < 65 && recent.size() != 0) return recent[$urandom_range(recent.size() - 1)];
        if (k < 90) return AW'($urandom_range(47));
        return AW'($urandom);
    endfunction

    task automatic run_random(int count);
        for (int i = 0; i < count; i++) send_access(pick_addr());
    endtask

    task automatic test_directed();
        // field extremes on the reset layout, then a fill/evict/promote sequence on two lists of two slots
        send_access('0);
        send_access({AW{1'b1}});
        send_access(31'h5555_5555);
        send_access(31'h2AAA_AAAA);
        send_access({AW{1'b1}});
        set_layout(2, 2, 2, 16, 16, 0, 0);
        send_access(31'd1); send_access(31'd2); send_access(31'd1);
        send_access(31'd3); send_access(31'd4); send_access(31'd3);
        send_access(31'd4); send_access(31'd3); send_access(31'd5);
    endtask

    task automatic test_bad_config();
        set_layout(0, 16, 16, 16, 16, 0, 0);
        send_access(31'd7);
        set_layout(5, 16, 16, 16, 16, 0, 0);
        send_access(31'd7);
        set_layout(2, 40, 30, 1, 1, 0, 0);
        send_access(31'd7);
        set_layout(3, 4, 0, 4, 4, 0, 0);
        send_access(31'd7);
        set_layout(7, 1, 1, 1, 1, 1, 1);
        send_access(31'd7);
    endtask

    task automatic test_plain_promotion();
        set_layout(4, 8, 6, 4, 3, 0, 0);
        run_random(200);
    endtask

    task automatic test_strict_promotion();
        set_layout(3, 10, 5, 7, 64, 1, 0);
        run_random(200);
    endtask

    task automatic test_lru_last();
        set_layout(2, 6, 5, 1, 1, 0, 1);
        run_random(150);
    endtask

    task automatic test_full_capacity();
        set_layout(4, 16, 16, 16, 16, 1, 1);
        idle_on = 0;
        run_random(150);
        idle_on = 1;
        set_layout(1, 64, 1, 1, 1, 0, 0);
        run_random(100);
        set_layout(4, 1, 1, 1, 61, 0, 1);
        run_random(100);
    endtask

    task automatic test_backpressure();
        set_layout(2, 3, 3, 1, 1, 1, 0);
        hold_off = 300;
        run_random(60);
    endtask

    // result side: random stall plus a long hold when requested
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off > 0) begin
                m_ready <= 1'b0;
                hold_off--;
            end else begin
                m_ready <= !(idle_on && $urandom_range(99) < 12);
            end
        end
    end

    initial begin
        access_result_t want, got;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got = '{m_hit, m_hit_list, m_hit_position, m_evicted_valid,
                        m_evicted_addr, m_access_count, m_miss_count,
                        m_fill_access_count, m_fill_miss_count, m_config_error};
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result transfer, actual %p", $time, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: result mismatch expected %p actual %p",
                                 $time, want, got);
                    end
                end
            end
        end
    end

    initial begin
        s_valid = 1'b0;
        s_addr = '0;
        cfg_we = 1'b0;
        cfg_index = sfc_pkg::CFG_NUM_LISTS;
        cfg_data = '0;
        aresetn = 1'b0;
        cur_lists = 3'd1;
        for (int i = 0; i < 4; i++) cur_size[i] = 7'd16;
        cur_strict = 1'b0;
        cur_lru = 1'b0;
        clear_cache();
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        test_bad_config();
        test_plain_promotion();
        test_strict_promotion();
        test_lru_last();
        test_full_capacity();
        test_backpressure();
        drain();
        if (expected_results.size() != 0) errors++;
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: segmented_fifo_cache_policy.f
rtl/sfc_pkg.sv
rtl/sfc_layout.sv
rtl/sfc_cell.sv
rtl/segmented_fifo_cache_policy.sv
tb/tb_segmented_fifo_cache_policy.sv
